@@ hdl/scns_pkg.sv @@
package scns_pkg;

  localparam int unsigned WIN_LEN  = 5;
  localparam int unsigned VIEW_LEN = WIN_LEN + 1;

  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] ONE_BYTE  = 8'h01;

  // Positions still inside a start code after its first byte
  localparam logic [2:0] SKIP_LONG  = 3'd4;
  localparam logic [2:0] SKIP_SHORT = 3'd3;

  typedef logic [VIEW_LEN-1:0][7:0] scns_view_t;

  typedef struct packed {
    logic       step;   // consume front byte of the view
    logic       clear;  // final flush step: return to reset state
    logic [2:0] n;      // number of valid bytes in the view
  } scns_ctl_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       lng;
    logic       last;
  } scns_res_t;

endpackage

@@ hdl/scns_cell.sv @@
module scns_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift,
  input  logic       wr,
  input  logic [7:0] wr_data,
  input  logic [7:0] nbr_data,
  input  logic       nbr_valid,
  output logic [7:0] eff_data,
  output logic       eff_valid,
  output logic       cur_valid
);
  import scns_pkg::*;

  logic [7:0] data_r, data_nxt;
  logic       valid_r, valid_nxt;

  // A byte written this cycle is already visible to the detector and neighbor
  assign eff_data  = wr ? wr_data : data_r;
  assign eff_valid = valid_r | wr;
  assign cur_valid = valid_r;

  always_comb begin
    data_nxt  = shift ? nbr_data  : eff_data;
    valid_nxt = shift ? nbr_valid : eff_valid;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

@@ hdl/scns_front.sv @@
module scns_front (
  input  logic                clk,
  input  logic                rst_n,
  input  scns_pkg::scns_view_t view,
  input  scns_pkg::scns_ctl_t  ctl,
  output logic                emit,
  output scns_pkg::scns_res_t  res
);
  import scns_pkg::*;

  logic       open_r, open_nxt;
  logic       lng_r, lng_nxt;
  logic [2:0] skip_r, skip_nxt;

  logic [VIEW_LEN-1:0] z, o;
  logic long0, short0, long1, short1;
  logic first, open_mid, c1, last;

  always_comb begin
    for (int k = 0; k < VIEW_LEN; k++) begin
      z[k] = (view[k] == ZERO_BYTE);
      o[k] = (view[k] == ONE_BYTE);
    end
    long0  = (ctl.n >= 3'd5) && z[0] && z[1] && z[2] && z[3] && o[4];
    short0 = (ctl.n >= 3'd4) && z[0] && z[1] && z[2] && o[3];
    long1  = (ctl.n >= 3'd6) && z[1] && z[2] && z[3] && z[4] && o[5];
    short1 = (ctl.n >= 3'd5) && z[1] && z[2] && z[3] && o[4];
  end

  always_comb begin
    first    = 1'b0;
    open_mid = open_r;
    lng_nxt  = lng_r;
    skip_nxt = skip_r;
    // long code wins over the short code it contains
    if (skip_r == 3'd0 && (long0 || short0)) begin
      first    = 1'b1;
      open_mid = 1'b1;
      lng_nxt  = long0;
      skip_nxt = long0 ? SKIP_LONG : SKIP_SHORT;
    end else if (skip_r != 3'd0) begin
      skip_nxt = skip_r - 3'd1;
    end
    c1       = (skip_nxt == 3'd0) && (long1 || short1);
    last     = c1 || (ctl.n == 3'd1);
    emit     = open_mid;
    open_nxt = open_mid && !last;
    res.data  = view[0];
    res.first = first;
    res.lng   = lng_nxt;
    res.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (ctl.step && ctl.clear)) begin
      open_r <= 1'b0;
      lng_r  <= 1'b0;
      skip_r <= 3'd0;
    end else if (ctl.step) begin
      open_r <= open_nxt;
      lng_r  <= lng_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

@@ hdl/h264_start_code_nal_splitter_core.sv @@
// NAL splitter on the start codes 00 00 00 01 and 00 00 00 00 01.
// Input channel (in_valid/in_ready): one stream byte per item, with
// in_stream_end marking the final byte of a stream. Output channel
// (out_valid/out_ready): one NAL byte per item, start code included, flagged
// with out_nal_first, out_nal_last and out_long_start (five-byte code).
// Bytes sit in a row of six cells; the front cell is judged against the
// five bytes behind it, so a byte leaves once five newer bytes are in.
// Throughput: one input item per cycle while streaming; the result for the
// byte accepted five items earlier is loaded at the accepting edge into an
// output register, so a stalled receiver only holds off input once that
// register is full and not being taken.
// Stream end: the buffered bytes, up to six, drain one per cycle while the
// output slot is free, all judged by the single detector at the front of the
// cell row; input is held off during the drain and the parser then returns
// to its reset state, so bytes ahead of the next start code are dropped again.
// Reset: synchronous, active low; empties the cells, closes any open NAL and
// empties the output register.
module h264_start_code_nal_splitter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_nal_first,
  output logic       out_long_start,
  output logic       out_nal_last
);
  import scns_pkg::*;

  logic [VIEW_LEN-1:0]      wr, eff_valid, cur_valid;
  logic [VIEW_LEN-1:0][7:0] eff_data;
  logic [VIEW_LEN-1:0][7:0] nbr_data;
  logic [VIEW_LEN-1:0]      nbr_valid;

  logic       flush_r, flush_nxt;
  logic       out_valid_r, out_valid_nxt;
  scns_res_t  res_r, res;
  logic       emit;
  logic       in_acc, slot_free, step;
  logic [2:0] fill, n;
  scns_ctl_t  ctl;

  // Output slot is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !flush_r && slot_free;
  assign in_acc    = in_valid && in_ready;

  assign fill = 3'($countones(cur_valid));
  assign n    = 3'($countones(eff_valid));

  // Advance the row when the view is full while streaming, or on every
  // free output slot while draining
  assign step = (in_acc && !in_stream_end && n == 3'(VIEW_LEN)) ||
                (flush_r && slot_free);

  assign ctl.step  = step;
  assign ctl.n     = n;
  assign ctl.clear = flush_r && (n == 3'd1);

  for (genvar i = 0; i < VIEW_LEN; i++) begin : g_cell
    // Write the incoming byte behind the last occupied cell
    assign wr[i] = in_acc && (fill == 3'(i));
    if (i == VIEW_LEN - 1) begin : g_tail
      assign nbr_data[i]  = ZERO_BYTE;
      assign nbr_valid[i] = 1'b0;
    end else begin : g_mid
      assign nbr_data[i]  = eff_data[i+1];
      assign nbr_valid[i] = eff_valid[i+1];
    end
    scns_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (step),
      .wr        (wr[i]),
      .wr_data   (in_byte),
      .nbr_data  (nbr_data[i]),
      .nbr_valid (nbr_valid[i]),
      .eff_data  (eff_data[i]),
      .eff_valid (eff_valid[i]),
      .cur_valid (cur_valid[i])
    );
  end

  scns_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .view  (eff_data),
    .ctl   (ctl),
    .emit  (emit),
    .res   (res)
  );

  always_comb begin
    flush_nxt = flush_r;
    if (in_acc && in_stream_end) begin
      flush_nxt = 1'b1;
    end else if (step && ctl.clear) begin
      flush_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = res_r.data;
  assign out_nal_first  = res_r.first;
  assign out_long_start = res_r.lng;
  assign out_nal_last   = res_r.last;

  // No input taken while draining
  a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    !(flush_r && in_ready))
    else $error("input accepted during drain");

  // Occupied cells always form a contiguous run from the front
  a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    ((cur_valid & (cur_valid + 6'd1)) == 6'd0))
    else $error("cell occupancy not contiguous");

  // While streaming, the sixth cell stays empty
  a_window_len: assert property (@(posedge clk) disable iff (!rst_n)
    !flush_r |-> !cur_valid[VIEW_LEN-1])
    else $error("window overfilled");

  // A finished drain leaves every cell empty
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(flush_r) |-> (cur_valid == 6'd0))
    else $error("cells not empty after drain");

endmodule

@@ tb/h264_start_code_nal_splitter_core_tb.sv @@
`timescale 1ns / 1ps

module h264_start_code_nal_splitter_core_tb;
  import scns_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int LIMIT_CYCLES = 400000;
  localparam int IDLE_PCT     = 21;
  // Receiver holds off once this many bytes are in, long enough to back up input
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 80;
  // Window of accepted bytes where neither side idles
  localparam int QUIET_FROM   = 380;
  localparam int QUIET_TO     = 470;
  // Bytes after the directed part at which the sender drains the block
  localparam int DRAIN_AFTER  = 300;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    logic [7:0] data;
    logic       stop;
  } stream_item_t;

  // Predicts the NAL bytes the splitter emits and checks them in order.
  class nal_split_scoreboard;
    logic [7:0]  window_bytes[WIN_LEN];
    logic [7:0]  view_bytes[VIEW_LEN];
    int unsigned held_count;
    bit          nal_is_open;
    bit          nal_is_long;
    logic [2:0]  code_skip;
    scns_res_t   expected_nal_bytes[$];
    int          errors;

    function new();
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (window_bytes[i]) window_bytes[i] = ZERO_BYTE;
      held_count  = 0;
      nal_is_open = 0;
      nal_is_long = 0;
      code_skip   = '0;
    endfunction

    // Start code at view position base+at, with n bytes valid from base
    function bit code_at(int base, int n, int at, output bit lng);
      int p;
      p = base + at;
      lng = 0;
      if (at + 5 <= n && view_bytes[p] == ZERO_BYTE && view_bytes[p+1] == ZERO_BYTE &&
          view_bytes[p+2] == ZERO_BYTE && view_bytes[p+3] == ZERO_BYTE &&
          view_bytes[p+4] == ONE_BYTE) begin
        lng = 1;
        return 1;
      end
      if (at + 4 <= n && view_bytes[p] == ZERO_BYTE && view_bytes[p+1] == ZERO_BYTE &&
          view_bytes[p+2] == ZERO_BYTE && view_bytes[p+3] == ONE_BYTE)
        return 1;
      return 0;
    endfunction

    // Judge the byte at base against the look-ahead behind it
    function void predict_front(int base, int n);
      bit        lng0;
      bit        lng1;
      bit        first;
      bit        next_code;
      bit        last;
      scns_res_t nal_byte;
      first = 0;
      if (code_skip == 0 && code_at(base, n, 0, lng0)) begin
        first       = 1;
        nal_is_open = 1;
        nal_is_long = lng0;
        code_skip   = lng0 ? SKIP_LONG : SKIP_SHORT;
      end else if (code_skip != 0) begin
        code_skip = code_skip - 3'd1;
      end
      next_code = (code_skip == 0) && code_at(base, n, 1, lng1);
      if (!nal_is_open) return;
      last = next_code || n == 1;
      nal_byte = '{data: view_bytes[base], first: first, lng: nal_is_long, last: last};
      expected_nal_bytes = {expected_nal_bytes, nal_byte};
      if (last) nal_is_open = 0;
    endfunction

    function void note_stream_byte(logic [7:0] data, logic stop);
      int fill;
      int n;
      fill = (held_count > WIN_LEN) ? WIN_LEN : held_count;
      foreach (window_bytes[i]) view_bytes[i] = window_bytes[i];
      view_bytes[WIN_LEN] = ZERO_BYTE;
      view_bytes[fill] = data;
      n = fill + 1;
      if (!stop) begin
        if (n == VIEW_LEN) begin
          predict_front(0, n);
          foreach (window_bytes[i]) window_bytes[i] = view_bytes[i+1];
          held_count = WIN_LEN;
        end else begin
          foreach (window_bytes[i]) window_bytes[i] = view_bytes[i];
          held_count = n;
        end
      end else begin
        // Flush every buffered byte, then start over as after reset
        for (int i = 0; i < n; i++) predict_front(i, n - i);
        clear_stream();
      end
    endfunction

    function void check_nal_byte(scns_res_t got);
      scns_res_t want;
      if (expected_nal_bytes.size() == 0) begin
        $display("%0t: unexpected NAL byte %h first %b long %b last %b",
                 $time, got.data, got.first, got.lng, got.last);
        errors++;
        return;
      end
      want = expected_nal_bytes.pop_front();
      if (got !== want) begin
        $display("%0t: NAL byte mismatch: expected %h first %b long %b last %b,",
                 $time, want.data, want.first, want.lng, want.last,
                 " actual %h first %b long %b last %b",
                 got.data, got.first, got.lng, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_nal_bytes.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_stream_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_nal_first;
  logic       out_long_start;
  logic       out_nal_last;

  nal_split_scoreboard sb;
  stream_item_t        stream_items[$];
  int                  directed_count;
  int                  bytes_taken = 0;
  int                  cycle_count = 0;

  h264_start_code_nal_splitter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_stream_end  (in_stream_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_nal_first  (out_nal_first),
    .out_long_start (out_long_start),
    .out_nal_last   (out_nal_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d NAL bytes still expected",
               cycle_count, sb.pending());
      $display("** h264_start_code_nal_splitter_core: FAILED **");
      $finish;
    end
  end

  // Sample both handshakes at the edge; predict on accepted stream bytes,
  // check every accepted NAL byte against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_stream_byte(in_byte, in_stream_end);
        bytes_taken++;
      end
      if (out_valid && out_ready)
        sb.check_nal_byte('{data: out_byte, first: out_nal_first,
                            lng: out_long_start, last: out_nal_last});
    end
  end

  function automatic bit quiet_window();
    return bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO;
  endfunction

  // Receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    bit held;
    held = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && bytes_taken >= HOLD_AT) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= quiet_window() ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
    end
  end

  task automatic add_byte(logic [7:0] data, logic stop);
    stream_item_t entry;
    entry.data = data;
    entry.stop = stop;
    stream_items = {stream_items, entry};
  endtask

  // Payload biased toward zero and one so stray codes and near-codes appear
  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return ZERO_BYTE;
    if (r < 30) return ONE_BYTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic add_start_code(bit lng, int extra_zeros);
    repeat (extra_zeros + (lng ? 4 : 3)) add_byte(ZERO_BYTE, 1'b0);
    add_byte(ONE_BYTE, 1'b0);
  endtask

  // Mostly well-formed streams; some pure noise and some cut inside a code
  task automatic add_random_stream();
    int kind;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)), 1'b0);
    end else if (kind < 16) begin
      repeat ($urandom_range(0, 3)) add_byte(payload_byte(), 1'b0);
      if ($urandom_range(1)) add_start_code(1'($urandom_range(1)), 0);
      repeat ($urandom_range(1, 4)) add_byte(ZERO_BYTE, 1'b0);
    end else begin
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(2, 255)), 1'b0);
      repeat ($urandom_range(1, 4)) begin
        add_start_code(1'($urandom_range(1)), int'($urandom_range(0, 2)));
        repeat ($urandom_range(1, 12)) add_byte(payload_byte(), 1'b0);
      end
    end
    // Now and then run the next stream on without an end mark
    if ($urandom_range(9) != 0) stream_items[stream_items.size()-1].stop = 1'b1;
  endtask

  task automatic send_byte(stream_item_t item);
    if (!quiet_window()) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_byte       <= item.data;
    in_stream_end <= item.stop;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every predicted NAL byte has come out
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();

    // Leading bytes are dropped, then a short code
    add_byte(8'hAA, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_start_code(1'b0, 0);
    add_byte(8'h65, 1'b0);
    add_byte(8'hFF, 1'b0);
    // Extra zero ahead of a long code: tail of the previous NAL
    add_start_code(1'b1, 1);
    add_byte(8'h41, 1'b0);
    add_start_code(1'b0, 0);
    add_byte(8'h09, 1'b0);
    // Code cut off by the end of the stream
    add_byte(ZERO_BYTE, 1'b0);
    add_byte(ZERO_BYTE, 1'b0);
    add_byte(ZERO_BYTE, 1'b1);
    // Short stream that is nothing but a start code
    add_start_code(1'b0, 0);
    stream_items[stream_items.size()-1].stop = 1'b1;
    directed_count = stream_items.size();

    while (stream_items.size() < directed_count + RANDOM_ITEMS) add_random_stream();
    stream_items[stream_items.size()-1].stop = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stream_items[i]) begin
      if (i == directed_count || i == directed_count + DRAIN_AFTER) drain_block();
      send_byte(stream_items[i]);
    end
    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** h264_start_code_nal_splitter_core: PASSED **");
    end else begin
      $display("** h264_start_code_nal_splitter_core: FAILED **");
    end
    $finish;
  end

endmodule
